### src/pcfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity checked frame receiver package
// Shared widths, operation and event codes and the result word type.
// ----------------------------------------------------------------------------
package pcfr_pkg;

   localparam int unsigned UnitWidth    = 16;
   localparam int unsigned LenWidth     = 7;
   localparam int unsigned ElapsedWidth = 23;
   localparam int unsigned EventWidth   = 3;

   localparam logic [ElapsedWidth-1:0] ElapsedMax = {ElapsedWidth{1'b1}};
   localparam logic [UnitWidth-1:0]    UnitReset  = 16'd50;
   localparam logic [7:0]              ParityMask = 8'h80;
   localparam logic [7:0]              LenMask    = 8'h7F;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [EventWidth-1:0] EV_HEADER  = 3'd0;
   localparam logic [EventWidth-1:0] EV_DATA    = 3'd1;
   localparam logic [EventWidth-1:0] EV_GOOD    = 3'd2;
   localparam logic [EventWidth-1:0] EV_PARITY  = 3'd3;
   localparam logic [EventWidth-1:0] EV_TIMEOUT = 3'd4;

   typedef struct packed {
      logic [EventWidth-1:0] event_res;
      logic [7:0]            frame_code;
      logic [7:0]            data_byte;
      logic [LenWidth-1:0]   byte_index;
      logic                  last;
   } rsp_type;

endpackage

### src/parity_checked_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Parity checked frame receiver
// Deframes code, header, payload and trailer bytes, checks even parity and
// enforces header and frame deadlines counted in timer ticks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  req      in         req_valid/req_stall  operation, rx_byte
//  rsp      out        rsp_valid/rsp_stall  event_res, frame_code, data_byte,
//                                           byte_index, last
//  csr      in         csr_valid/csr_ready  ticks_per_byte_timeout
//
// One word is taken per cycle unless req_stall holds it; its result is
// registered into the output buffer. The frame deadline is a 7 x 16 product
// kept in a register, computed from the next length and timeout unit so ticks
// compare against it directly. A two-entry output buffer keeps input flowing
// while a result waits; the input stalls only when both entries are full.
// Reset is synchronous and returns the receiver to idle with the unit at 50.
// ----------------------------------------------------------------------------
module parity_checked_frame_receiver_top
   import pcfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [EventWidth-1:0] rsp_event_res,
   output logic [7:0]            rsp_frame_code,
   output logic [7:0]            rsp_data_byte,
   output logic [LenWidth-1:0]   rsp_byte_index,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [UnitWidth-1:0]  csr_ticks_per_byte_timeout
);

   localparam logic [1:0] PH_IDLE    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_PAYLOAD = 2'd2;
   localparam logic [1:0] PH_TRAILER = 2'd3;

   logic [1:0]              phase_ff, phase_in;
   logic [7:0]              code_ff, code_in;
   logic [LenWidth-1:0]     len_ff, len_in;
   logic [LenWidth-1:0]     count_rx_ff, count_rx_in;
   logic                    parity_ff, parity_in;
   logic [ElapsedWidth-1:0] elapsed_ff, elapsed_in;
   logic [UnitWidth-1:0]    unit_ff, unit_in;
   logic [ElapsedWidth-1:0] deadline_ff, deadline_in;

   logic [1:0]              fill_ff, fill_in;
   rsp_type                 head_ff, head_in;
   rsp_type                 skid_ff, skid_in;

   logic                    accept;
   logic                    pop;
   logic                    push;
   rsp_type                 result;
   logic [ElapsedWidth-1:0] elapsed_inc;
   logic [LenWidth-1:0]     count_next;
   logic [LenWidth-1:0]     len_eff;
   logic                    late;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (fill_ff == 2'd2);
   assign rsp_valid = (fill_ff != 2'd0);
   assign pop       = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   assign elapsed_inc = (elapsed_ff == ElapsedMax) ? elapsed_ff
                                                   : elapsed_ff + 1'b1;
   assign count_next  = count_rx_ff + 1'b1;

   always_comb begin
      if (phase_ff == PH_HEADER) begin
         late = elapsed_inc > ElapsedWidth'(unit_ff);
      end else begin
         late = elapsed_inc >= deadline_ff;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      code_in     = code_ff;
      len_in      = len_ff;
      count_rx_in = count_rx_ff;
      parity_in   = parity_ff;
      elapsed_in  = elapsed_ff;
      push        = 1'b0;
      result      = '{event_res: EV_TIMEOUT, frame_code: code_ff, data_byte: 8'd0,
                      byte_index: '0, last: 1'b1};
      if (accept) begin
         if (req_operation == OP_TICK) begin
            if (phase_ff != PH_IDLE) begin
               elapsed_in = elapsed_inc;
               if (late) begin
                  push     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  code_in     = req_rx_byte;
                  parity_in   = ^req_rx_byte;
                  elapsed_in  = '0;
                  len_in      = '0;
                  count_rx_in = '0;
                  phase_in    = PH_HEADER;
               end
               PH_HEADER: begin
                  len_in      = LenWidth'(req_rx_byte & LenMask);
                  parity_in   = parity_ff ^ (^req_rx_byte);
                  count_rx_in = '0;
                  phase_in    = (len_in == '0) ? PH_TRAILER : PH_PAYLOAD;
                  push        = 1'b1;
                  result.event_res  = EV_HEADER;
                  result.byte_index = len_in;
                  result.last       = 1'b0;
               end
               PH_PAYLOAD: begin
                  parity_in   = parity_ff ^ (^req_rx_byte);
                  count_rx_in = count_next;
                  if (count_next == len_ff) begin
                     phase_in = PH_TRAILER;
                  end
                  push        = 1'b1;
                  result.event_res  = EV_DATA;
                  result.data_byte  = req_rx_byte;
                  result.byte_index = count_rx_ff;
                  result.last       = 1'b0;
               end
               default: begin
                  push     = 1'b1;
                  phase_in = PH_IDLE;
                  result.event_res = parity_ff ? EV_PARITY : EV_GOOD;
               end
            endcase
         end
      end
   end

   // The deadline follows the values the next word will see, so it is never stale.
   assign unit_in     = csr_valid ? csr_ticks_per_byte_timeout : unit_ff;
   assign len_eff     = (len_in == '0) ? LenWidth'(1) : len_in;
   assign deadline_in = ElapsedWidth'(len_eff) * ElapsedWidth'(unit_in);

   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (push && pop) begin
         if (fill_ff == 2'd1) begin
            head_in = result;
         end else begin
            head_in = skid_ff;
            skid_in = result;
         end
      end else if (push) begin
         fill_in = fill_ff + 2'd1;
         if (fill_ff == 2'd0) begin
            head_in = result;
         end else begin
            skid_in = result;
         end
      end else if (pop) begin
         fill_in = fill_ff - 2'd1;
         head_in = skid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         code_ff     <= '0;
         len_ff      <= '0;
         count_rx_ff <= '0;
         parity_ff   <= 1'b0;
         elapsed_ff  <= '0;
         unit_ff     <= UnitReset;
         deadline_ff <= ElapsedWidth'(UnitReset);
         fill_ff     <= 2'd0;
      end else begin
         phase_ff    <= phase_in;
         code_ff     <= code_in;
         len_ff      <= len_in;
         count_rx_ff <= count_rx_in;
         parity_ff   <= parity_in;
         elapsed_ff  <= elapsed_in;
         unit_ff     <= unit_in;
         deadline_ff <= deadline_in;
         fill_ff     <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_event_res  = head_ff.event_res;
   assign rsp_frame_code = head_ff.frame_code;
   assign rsp_data_byte  = head_ff.data_byte;
   assign rsp_byte_index = head_ff.byte_index;
   assign rsp_last       = head_ff.last;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("output buffer fill out of range");

   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_rx_ff < len_ff)
      else $error("payload count passed the frame length");

   a_status_ends_frame: assert property (@(posedge clock) disable iff (reset)
      push && result.last |=> phase_ff == PH_IDLE)
      else $error("status word did not return the receiver to idle");

   a_last_matches_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_last == (rsp_event_res == EV_GOOD || rsp_event_res == EV_PARITY
                                 || rsp_event_res == EV_TIMEOUT))
      else $error("last flag does not match event");

endmodule
